### rtl/rsitt_pkg.sv
// Shared types and constants of the strength-index threshold trader.
// No dependencies; every other file of the block imports this package.

package rsitt_pkg;

   // Field widths fixed by the register map and the result word
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int WLEN_W     = 7;
   localparam int LEVEL_W    = 7;
   localparam int MAXPOS_W   = 16;
   localparam int POS_W      = 17;
   localparam int CASH_W     = 48;
   localparam int ACTION_W   = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POSITION     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERSOLD_LEVEL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERBOUGHT_LEVEL = 2'd3;

   // Register reset values
   localparam int                    WLEN_RESET       = 13;
   localparam logic [MAXPOS_W-1:0]   MAXPOS_RESET     = 16'd100;
   localparam logic [LEVEL_W-1:0]    OVERSOLD_RESET   = 7'd30;
   localparam logic [LEVEL_W-1:0]    OVERBOUGHT_RESET = 7'd70;

   // Full scale of the index in percent
   localparam logic [LEVEL_W-1:0]    HUNDRED          = 7'd100;

   // Order placed for one day
   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE = 2'd0,
      ACT_BUY  = 2'd1,
      ACT_SELL = 2'd2
   } action_type;

   // Per-cell control of the difference chain
   typedef struct packed {
      logic shift;    // a new difference enters this cycle
      logic load;     // this cell is the entry point
      logic follow;   // this cell takes its neighbor's value
   } cell_ctl_type;

   // Trading limits seen by the decision stages
   typedef struct packed {
      logic [MAXPOS_W-1:0] max_position;
      logic [LEVEL_W-1:0]  oversold_level;
      logic [LEVEL_W-1:0]  overbought_level;
   } trade_cfg_type;

   // Load strobes of the stages behind the window
   typedef struct packed {
      logic adv2;
      logic adv3;
      logic adv4;
   } stage_adv_type;

endpackage

### rtl/rsitt_ifs.sv
// Valid/ready channel interfaces of the trader: price words in, result words out.
// Depends on rsitt_pkg for the result field widths.

interface rsitt_req_if #(
   parameter int PRICE_BITS = 24
) ();
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] price;
   logic                  in_range;
   logic                  final_day;

   modport source (output valid, output price, output in_range, output final_day,
                   input ready);
   modport sink   (input valid, input price, input in_range, input final_day,
                   output ready);
endinterface

interface rsitt_rsp_if import rsitt_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [CASH_W-1:0]   cash;
   logic signed [POS_W-1:0]    position;
   logic                       window_ready;
   logic                       is_final;
   logic signed [CASH_W-1:0]   close_pnl;

   modport source (output valid, output action, output cash, output position,
                   output window_ready, output is_final, output close_pnl,
                   input ready);
   modport sink   (input valid, input action, input cash, input position,
                   input window_ready, input is_final, input close_pnl,
                   output ready);
endinterface

### rtl/rsitt_cell.sv
// One cell of the price-difference chain: holds one difference and passes it on.
// Depends on rsitt_pkg for the cell control struct.

module rsitt_cell import rsitt_pkg::*; #(
   parameter int WIDTH = 25
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [WIDTH-1:0] load_data,
   input  logic [WIDTH-1:0] neighbor,
   output logic [WIDTH-1:0] cell_out
);

   logic [WIDTH-1:0] diff_ff;

   // Take the new difference at the entry point, else move the neighbor's along
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         if (ctl.load) begin
            diff_ff <= load_data;
         end else if (ctl.follow) begin
            diff_ff <= neighbor;
         end
      end
   end

   assign cell_out = diff_ff;

endmodule

### rtl/rsitt_window.sv
// Sliding window of price differences with running gain and loss sums.
// Depends on rsitt_pkg and rsitt_cell; holds the first pipeline register.

module rsitt_window import rsitt_pkg::*; #(
   parameter int WINDOW_MAX = 64,
   parameter int PRICE_BITS = 24,
   localparam int NW        = $clog2(WINDOW_MAX + 1),
   localparam int SUM_W     = PRICE_BITS + $clog2(WINDOW_MAX)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  clear,
   input  logic [NW-1:0]         wlen_n,
   input  logic [PRICE_BITS-1:0] price,
   input  logic                  in_range,
   input  logic                  final_day,
   output logic [SUM_W-1:0]      s1_gain,
   output logic [SUM_W-1:0]      s1_loss,
   output logic                  s1_ready,
   output logic [PRICE_BITS-1:0] s1_price,
   output logic                  s1_in_range,
   output logic                  s1_final
);

   localparam int DW    = PRICE_BITS + 1;
   localparam int IDX_W = $clog2(WINDOW_MAX);

   logic [PRICE_BITS-1:0] prev_price_ff;
   logic                  have_prev_ff;
   logic [NW-1:0]         fill_ff, fill_in;
   logic [SUM_W-1:0]      gain_ff, gain_in;
   logic [SUM_W-1:0]      loss_ff, loss_in;
   logic [SUM_W-1:0]      gain_q_ff, loss_q_ff;
   logic                  ready_q_ff;
   logic [PRICE_BITS-1:0] price_q_ff;
   logic                  in_range_q_ff, final_q_ff;

   logic                  step;
   logic                  full;
   logic [DW-1:0]         diff_new, diff_neg, old_neg;
   logic [DW-1:0]         diff_old;
   logic [NW-1:0]         entry_full;
   logic [IDX_W-1:0]      entry;
   logic [SUM_W-1:0]      add_gain, add_loss, sub_gain, sub_loss;
   logic [DW-1:0]         cell_q [WINDOW_MAX];

   // Difference of this price to the last one
   assign step     = accept && have_prev_ff;
   assign full     = (fill_ff >= wlen_n);
   assign diff_new = {1'b0, price} - {1'b0, prev_price_ff};
   assign diff_neg = -diff_new;
   assign diff_old = cell_q[WINDOW_MAX-1];
   assign old_neg  = -diff_old;

   // Entry point: a difference reaches the last cell after wlen_n steps
   assign entry_full = NW'(WINDOW_MAX) - wlen_n;
   assign entry      = entry_full[IDX_W-1:0];

   // Build the chain
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_chain
      cell_ctl_type   ctl;
      logic [DW-1:0]  nb;

      assign ctl.shift  = step;
      assign ctl.load   = (IDX_W'(i) == entry);
      assign ctl.follow = (IDX_W'(i) > entry);

      if (i == 0) begin : g_head
         assign nb = '0;
      end else begin : g_link
         assign nb = cell_q[i-1];
      end

      rsitt_cell #(
         .WIDTH (DW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_data (diff_new),
         .neighbor  (nb),
         .cell_out  (cell_q[i])
      );
   end

   // Sum terms: add the new difference, drop the one leaving the window
   always_comb begin
      add_gain = '0;
      add_loss = '0;
      sub_gain = '0;
      sub_loss = '0;
      if (step) begin
         if (diff_new[DW-1]) begin
            add_loss = SUM_W'(diff_neg[PRICE_BITS-1:0]);
         end else begin
            add_gain = SUM_W'(diff_new[PRICE_BITS-1:0]);
         end
         if (full) begin
            if (diff_old[DW-1]) begin
               sub_loss = SUM_W'(old_neg[PRICE_BITS-1:0]);
            end else begin
               sub_gain = SUM_W'(diff_old[PRICE_BITS-1:0]);
            end
         end
      end
   end

   assign gain_in = gain_ff + add_gain - sub_gain;
   assign loss_in = loss_ff + add_loss - sub_loss;
   assign fill_in = (step && !full) ? fill_ff + NW'(1) : fill_ff;

   // Window state: clear on a window length write, advance on each word
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_price_ff <= '0;
         have_prev_ff  <= 1'b0;
         fill_ff       <= '0;
         gain_ff       <= '0;
         loss_ff       <= '0;
      end else if (clear) begin
         fill_ff       <= '0;
         gain_ff       <= '0;
         loss_ff       <= '0;
      end else if (accept) begin
         prev_price_ff <= price;
         have_prev_ff  <= 1'b1;
         fill_ff       <= fill_in;
         gain_ff       <= gain_in;
         loss_ff       <= loss_in;
      end
   end

   // First pipeline register
   always_ff @(posedge clock) begin
      if (accept) begin
         gain_q_ff     <= gain_in;
         loss_q_ff     <= loss_in;
         ready_q_ff    <= (fill_in >= wlen_n);
         price_q_ff    <= price;
         in_range_q_ff <= in_range;
         final_q_ff    <= final_day;
      end
   end

   assign s1_gain     = gain_q_ff;
   assign s1_loss     = loss_q_ff;
   assign s1_ready    = ready_q_ff;
   assign s1_price    = price_q_ff;
   assign s1_in_range = in_range_q_ff;
   assign s1_final    = final_q_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= wlen_n)
      else $error("fill count beyond window length");

   a_empty_sums: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (gain_ff == '0 && loss_ff == '0))
      else $error("sums nonzero with empty window");

   a_first_price: assert property (@(posedge clock) disable iff (reset)
      !have_prev_ff |-> (fill_ff == '0))
      else $error("difference counted before first price");

endmodule

### rtl/rsitt_trade.sv
// Index compare and order stages: products, threshold flags, position and cash.
// Depends on rsitt_pkg; fed by rsitt_window's registered sums.

module rsitt_trade import rsitt_pkg::*; #(
   parameter int PRICE_BITS = 24,
   parameter int SUM_W      = 30
) (
   input  logic                     clock,
   input  logic                     reset,
   input  stage_adv_type            adv,
   input  trade_cfg_type            cfg,
   input  logic [SUM_W-1:0]         s1_gain,
   input  logic [SUM_W-1:0]         s1_loss,
   input  logic                     s1_ready,
   input  logic [PRICE_BITS-1:0]    s1_price,
   input  logic                     s1_in_range,
   input  logic                     s1_final,
   output action_type               action,
   output logic signed [CASH_W-1:0] cash,
   output logic signed [POS_W-1:0]  position,
   output logic                     window_ready,
   output logic                     is_final,
   output logic signed [CASH_W-1:0] close_pnl
);

   localparam int PROD_W = SUM_W + LEVEL_W;
   localparam int MUL_W  = PRICE_BITS + POS_W + 1;
   localparam int WIDE_W = ((MUL_W > CASH_W) ? MUL_W : CASH_W) + 2;

   // Stage 2 registers
   logic [PROD_W-1:0]      prod_gain_ff, prod_os_ff, prod_ob_ff;
   logic                   loss_zero_ff, en2_ff, ready2_ff, final2_ff;
   logic [PRICE_BITS-1:0]  price2_ff;
   // Stage 3 registers
   logic                   below_ff, above_ff, en3_ff, ready3_ff, final3_ff;
   logic [PRICE_BITS-1:0]  price3_ff;
   // Trading state
   logic signed [CASH_W-1:0] cash_bal_ff;
   logic signed [POS_W-1:0]  held_ff;
   // Result word
   action_type               act_ff;
   logic signed [CASH_W-1:0] out_cash_ff, out_pnl_ff;
   logic signed [POS_W-1:0]  out_pos_ff;
   logic                     out_ready_ff, out_final_ff;

   logic [SUM_W-1:0]         total;
   logic                     below, above;
   logic                     buy, sell;
   logic signed [POS_W-1:0]  max_s, held_new;
   logic signed [PRICE_BITS:0] price_s;
   logic signed [MUL_W-1:0]  prod;
   logic signed [WIDE_W-1:0] price_w, cash_w, cash_raw, dprice_w, pnl_raw;
   logic signed [CASH_W-1:0] cash_new, pnl;

   function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-CASH_W:0] top;
      logic signed [CASH_W-1:0] res;
      top = v[WIDE_W-1:CASH_W-1];
      if (top == '0 || top == '1) begin
         res = v[CASH_W-1:0];
      end else if (v[WIDE_W-1]) begin
         res = {1'b1, {(CASH_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(CASH_W-1){1'b1}}};
      end
      return res;
   endfunction

   // Stage 2: scale the sums for the division-free compare
   assign total = s1_gain + s1_loss;

   always_ff @(posedge clock) begin
      if (adv.adv2) begin
         prod_gain_ff <= PROD_W'(s1_gain) * PROD_W'(HUNDRED);
         prod_os_ff   <= PROD_W'(cfg.oversold_level) * PROD_W'(total);
         prod_ob_ff   <= PROD_W'(cfg.overbought_level) * PROD_W'(total);
         loss_zero_ff <= (s1_loss == '0);
         en2_ff       <= s1_ready && s1_in_range;
         ready2_ff    <= s1_ready;
         final2_ff    <= s1_final;
         price2_ff    <= s1_price;
      end
   end

   // Stage 3: threshold flags, full scale when there are no losses
   assign below = loss_zero_ff ? (HUNDRED < cfg.oversold_level)
                               : (prod_gain_ff < prod_os_ff);
   assign above = loss_zero_ff ? (HUNDRED > cfg.overbought_level)
                               : (prod_gain_ff > prod_ob_ff);

   always_ff @(posedge clock) begin
      if (adv.adv3) begin
         below_ff  <= below;
         above_ff  <= above;
         en3_ff    <= en2_ff;
         ready3_ff <= ready2_ff;
         final3_ff <= final2_ff;
         price3_ff <= price2_ff;
      end
   end

   // Stage 4: order within the position limit, then close on the final day
   assign max_s    = {1'b0, cfg.max_position};
   assign buy      = en3_ff && below_ff && (held_ff < max_s);
   assign sell     = en3_ff && !buy && above_ff && (held_ff > -max_s);
   assign held_new = buy ? held_ff + POS_W'(1) : (sell ? held_ff - POS_W'(1) : held_ff);

   assign price_w  = WIDE_W'({1'b0, price3_ff});
   assign cash_w   = {{(WIDE_W-CASH_W){cash_bal_ff[CASH_W-1]}}, cash_bal_ff};
   assign cash_raw = buy ? cash_w - price_w : (sell ? cash_w + price_w : cash_w);
   assign cash_new = sat_cash(cash_raw);

   // Held units after the trade times price, built from the held units before it
   assign price_s  = {1'b0, price3_ff};
   assign prod     = held_ff * price_s;
   assign dprice_w = buy ? price_w : (sell ? -price_w : '0);
   assign pnl_raw  = {{(WIDE_W-CASH_W){cash_new[CASH_W-1]}}, cash_new}
                   + {{(WIDE_W-MUL_W){prod[MUL_W-1]}}, prod} + dprice_w;
   assign pnl      = sat_cash(pnl_raw);

   // Trading state
   always_ff @(posedge clock) begin
      if (reset) begin
         cash_bal_ff <= '0;
         held_ff     <= '0;
      end else if (adv.adv4) begin
         cash_bal_ff <= final3_ff ? pnl : cash_new;
         held_ff     <= final3_ff ? '0 : held_new;
      end
   end

   // Result word
   always_ff @(posedge clock) begin
      if (adv.adv4) begin
         act_ff       <= buy ? ACT_BUY : (sell ? ACT_SELL : ACT_NONE);
         out_cash_ff  <= cash_new;
         out_pos_ff   <= held_new;
         out_ready_ff <= ready3_ff;
         out_final_ff <= final3_ff;
         out_pnl_ff   <= final3_ff ? pnl : '0;
      end
   end

   assign action       = act_ff;
   assign cash         = out_cash_ff;
   assign position     = out_pos_ff;
   assign window_ready = out_ready_ff;
   assign is_final     = out_final_ff;
   assign close_pnl    = out_pnl_ff;

endmodule

### rtl/rsi_threshold_trader_unit.sv
// Top level of the strength-index threshold trader: channels, registers, pipeline.
// Depends on rsitt_pkg, rsitt_ifs, rsitt_window and rsitt_trade.
//
// Usage: req_chan carries one word per trading day (price, in_range,
// final_day); rsp_chan returns one result word per day, in order
// (action, cash, position, window_ready, is_final, close_pnl).
// The csr_ port writes the window length, position limit and the two
// thresholds; write only while no word is in flight. A window length
// write empties the window.
// A day's word passes the window, product, flag and result stages in
// order. Throughput: one word per cycle while rsp_chan does not stall;
// two loops bound it: the window sum update (add new difference, drop
// the oldest) and the order stage (position, cash and closing product).
// Reset (synchronous) restores register defaults, empties the window and
// clears position and cash; no clearing pass is needed.
// When rsp_chan stalls, the four stages fill up in turn; req_chan.ready
// drops only once every stage holds a word.

module rsi_threshold_trader_unit import rsitt_pkg::*; #(
   parameter int WINDOW_MAX = 64,
   parameter int PRICE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   rsitt_req_if.sink             req_chan,
   rsitt_rsp_if.source           rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NW      = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W   = PRICE_BITS + $clog2(WINDOW_MAX);
   localparam int N_RESET = (WLEN_RESET > WINDOW_MAX) ? WINDOW_MAX : WLEN_RESET;

   logic [NW-1:0]        wlen_n_ff, wlen_n_in;
   logic [MAXPOS_W-1:0]  max_pos_ff;
   logic [LEVEL_W-1:0]   oversold_ff, overbought_ff;
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic                 free1, free2, free3, free4;
   logic                 accept, clear;
   stage_adv_type        adv;
   trade_cfg_type        cfg;
   logic [WLEN_W-1:0]    wl;
   logic [PRICE_BITS-1:0] price;

   logic [SUM_W-1:0]      s1_gain, s1_loss;
   logic                  s1_ready, s1_in_range, s1_final;
   logic [PRICE_BITS-1:0] s1_price;
   action_type            action;

   // Window length limited to 1..WINDOW_MAX
   assign wl = csr_wdata[WLEN_W-1:0];
   always_comb begin
      if (wl == '0) begin
         wlen_n_in = NW'(1);
      end else if (32'(wl) > 32'(WINDOW_MAX)) begin
         wlen_n_in = NW'(WINDOW_MAX);
      end else begin
         wlen_n_in = NW'(wl);
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_n_ff     <= NW'(N_RESET);
         max_pos_ff    <= MAXPOS_RESET;
         oversold_ff   <= OVERSOLD_RESET;
         overbought_ff <= OVERBOUGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH:    wlen_n_ff     <= wlen_n_in;
            CSR_MAX_POSITION:     max_pos_ff    <= csr_wdata[MAXPOS_W-1:0];
            CSR_OVERSOLD_LEVEL:   oversold_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_OVERBOUGHT_LEVEL: overbought_ff <= csr_wdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign clear = csr_write_en && (csr_index == CSR_WINDOW_LENGTH);
   assign cfg.max_position     = max_pos_ff;
   assign cfg.oversold_level   = oversold_ff;
   assign cfg.overbought_level = overbought_ff;

   // Stage handshake: a stage loads when it is empty or its word moves on
   assign free4    = !v4_ff || rsp_chan.ready;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;
   assign adv.adv4 = v3_ff && free4;
   assign adv.adv3 = v2_ff && free3;
   assign adv.adv2 = v1_ff && free2;
   assign accept   = req_chan.valid && free1;

   assign req_chan.ready = free1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept   || (v1_ff && !free2);
         v2_ff <= adv.adv2 || (v2_ff && !free3);
         v3_ff <= adv.adv3 || (v3_ff && !free4);
         v4_ff <= adv.adv4 || (v4_ff && !rsp_chan.ready);
      end
   end

   assign price = req_chan.price;

   rsitt_window #(
      .WINDOW_MAX (WINDOW_MAX),
      .PRICE_BITS (PRICE_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .clear       (clear),
      .wlen_n      (wlen_n_ff),
      .price       (price),
      .in_range    (req_chan.in_range),
      .final_day   (req_chan.final_day),
      .s1_gain     (s1_gain),
      .s1_loss     (s1_loss),
      .s1_ready    (s1_ready),
      .s1_price    (s1_price),
      .s1_in_range (s1_in_range),
      .s1_final    (s1_final)
   );

   rsitt_trade #(
      .PRICE_BITS (PRICE_BITS),
      .SUM_W      (SUM_W)
   ) u_trade (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .cfg          (cfg),
      .s1_gain      (s1_gain),
      .s1_loss      (s1_loss),
      .s1_ready     (s1_ready),
      .s1_price     (s1_price),
      .s1_in_range  (s1_in_range),
      .s1_final     (s1_final),
      .action       (action),
      .cash         (rsp_chan.cash),
      .position     (rsp_chan.position),
      .window_ready (rsp_chan.window_ready),
      .is_final     (rsp_chan.is_final),
      .close_pnl    (rsp_chan.close_pnl)
   );

   assign rsp_chan.valid  = v4_ff;
   assign rsp_chan.action = action;

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted word not held in first stage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_chan.ready))
      else $error("input stalled with a free stage");

   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(v3_ff))
      else $error("result word without a word in stage three");

endmodule

### sim/tb_rsi_threshold_trader_unit.sv
// Testbench of rsi_threshold_trader_unit: directed and random price words, checked
// word by word against a scoreboard that tracks the strength-index window and trades.
// Depends on rtl/rsitt_pkg.sv, rtl/rsitt_ifs.sv and the RTL of the trader.

module tb_rsi_threshold_trader_unit;
   import rsitt_pkg::*;

   localparam int     PRICE_W    = 24;
   localparam int     RING_DEPTH = 64;
   localparam int     PRICE_TOP  = (1 << PRICE_W) - 1;
   localparam longint CASH_HI    = (longint'(1) << (CASH_W - 1)) - 1;
   localparam longint CASH_LO    = -CASH_HI - 1;

   // One result word as the block reports it
   typedef struct {
      logic [ACTION_W-1:0]      action;
      logic signed [CASH_W-1:0] cash;
      logic signed [POS_W-1:0]  position;
      logic                     window_ready;
      logic                     is_final;
      logic signed [CASH_W-1:0] close_pnl;
   } day_report_type;

   // Scoreboard: tracks the window, position and cash, and holds the reports due
   class trade_ledger_type;
      bit [WLEN_W-1:0]   window_length;
      bit [MAXPOS_W-1:0] max_position;
      bit [LEVEL_W-1:0]  oversold_level;
      bit [LEVEL_W-1:0]  overbought_level;
      bit [PRICE_W-1:0]  last_price;
      bit                seen_price;
      longint            diff_ring [RING_DEPTH];
      int unsigned       ring_head;
      int unsigned       filled;
      longint            gains;
      longint            losses;
      longint            units;
      longint            cash;
      day_report_type    pending_reports [$];
      int unsigned       mismatches;

      function new();
         window_length    = WLEN_W'(WLEN_RESET);
         max_position     = MAXPOS_RESET;
         oversold_level   = OVERSOLD_RESET;
         overbought_level = OVERBOUGHT_RESET;
         last_price       = '0;
         seen_price       = 1'b0;
         foreach (diff_ring[i]) diff_ring[i] = 0;
         units            = 0;
         cash             = 0;
         mismatches       = 0;
         empty_window();
      endfunction

      function void empty_window();
         ring_head = 0;
         filled    = 0;
         gains     = 0;
         losses    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WINDOW_LENGTH: begin
               window_length = value[WLEN_W-1:0];
               empty_window();
            end
            CSR_MAX_POSITION:     max_position     = value[MAXPOS_W-1:0];
            CSR_OVERSOLD_LEVEL:   oversold_level   = value[LEVEL_W-1:0];
            CSR_OVERBOUGHT_LEVEL: overbought_level = value[LEVEL_W-1:0];
            default: ;
         endcase
      endfunction

      // Add a difference to its sum, or take it back out
      function void book_diff(longint d, bit add);
         if (d > 0) gains = add ? gains + d : gains - d;
         else if (d < 0) losses = add ? losses - d : losses + d;
      endfunction

      function longint clip_cash(longint v);
         if (v > CASH_HI) return CASH_HI;
         if (v < CASH_LO) return CASH_LO;
         return v;
      endfunction

      // Advance the window by one day, trade, and queue the report it causes
      function void take_day(bit [PRICE_W-1:0] price, bit in_range, bit final_day);
         int unsigned    span;
         int unsigned    oldest;
         longint         d;
         longint         total;
         bit             full;
         bit             below;
         bit             above;
         day_report_type want;

         if (window_length == 0) span = 1;
         else if (window_length > RING_DEPTH) span = RING_DEPTH;
         else span = window_length;

         // Slide: drop the oldest difference once full, then add the new one
         if (seen_price) begin
            d = longint'(price) - longint'(last_price);
            if (filled >= span) begin
               oldest = (ring_head + RING_DEPTH - span) % RING_DEPTH;
               book_diff(diff_ring[oldest], 1'b0);
            end else begin
               filled++;
            end
            diff_ring[ring_head] = d;
            book_diff(d, 1'b1);
            ring_head = (ring_head + 1) % RING_DEPTH;
         end
         last_price = price;
         seen_price = 1'b1;
         full = (filled >= span);

         want.action = ACT_NONE;
         if (full && in_range) begin
            total = gains + losses;
            if (losses == 0) begin
               below = longint'(HUNDRED) < longint'(oversold_level);
               above = longint'(HUNDRED) > longint'(overbought_level);
            end else begin
               below = longint'(HUNDRED) * gains < longint'(oversold_level) * total;
               above = longint'(HUNDRED) * gains > longint'(overbought_level) * total;
            end
            if (below && units < longint'(max_position)) begin
               cash = clip_cash(cash - longint'(price));
               units++;
               want.action = ACT_BUY;
            end else if (above && units > -longint'(max_position)) begin
               cash = clip_cash(cash + longint'(price));
               units--;
               want.action = ACT_SELL;
            end
         end

         want.cash         = cash[CASH_W-1:0];
         want.position     = units[POS_W-1:0];
         want.window_ready = full;
         want.is_final     = final_day;
         want.close_pnl    = '0;

         // Close the position at today's price
         if (final_day) begin
            cash           = clip_cash(cash + units * longint'(price));
            units          = 0;
            want.close_pnl = cash[CASH_W-1:0];
         end
         pending_reports.insert(pending_reports.size(), want);
      endfunction

      function void check_report(day_report_type got);
         day_report_type want;
         if (pending_reports.size() == 0) begin
            $error("result word with nothing pending");
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            mismatches++;
         end
         if (got.cash !== want.cash) begin
            $error("cash: expected %0d, got %0d", want.cash, got.cash);
            mismatches++;
         end
         if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            mismatches++;
         end
         if (got.window_ready !== want.window_ready) begin
            $error("window_ready: expected %0d, got %0d", want.window_ready, got.window_ready);
            mismatches++;
         end
         if (got.is_final !== want.is_final) begin
            $error("is_final: expected %0d, got %0d", want.is_final, got.is_final);
            mismatches++;
         end
         if (got.close_pnl !== want.close_pnl) begin
            $error("close_pnl: expected %0d, got %0d", want.close_pnl, got.close_pnl);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    steady;
   int                    walk_price;
   int                    trend;
   trade_ledger_type      ledger = new();

   rsitt_req_if #(.PRICE_BITS(PRICE_W)) req_chan ();
   rsitt_rsp_if                         rsp_chan ();

   rsi_threshold_trader_unit #(
      .WINDOW_MAX(RING_DEPTH),
      .PRICE_BITS(PRICE_W)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Hard stop in case the block hangs
   initial begin
      #3000000;
      $display("tb_rsi_threshold_trader_unit: done, errors");
      $finish;
   end

   // Stall the result channel at random, except in steady stretches
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 15);
      end
   end

   // Note accepted days first, then check returned words
   always @(posedge clock) begin
      day_report_type seen;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            ledger.take_day(req_chan.price, req_chan.in_range, req_chan.final_day);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.action       = rsp_chan.action;
            seen.cash         = rsp_chan.cash;
            seen.position     = rsp_chan.position;
            seen.window_ready = rsp_chan.window_ready;
            seen.is_final     = rsp_chan.is_final;
            seen.close_pnl    = rsp_chan.close_pnl;
            ledger.check_report(seen);
         end
      end
   end

   // Offer one day's word, idling first at random; return once it is taken
   task automatic send_day(logic [PRICE_W-1:0] price, logic in_range, logic final_day);
      while (!steady && $urandom_range(0, 99) < 15) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.price     <= price;
      req_chan.in_range  <= in_range;
      req_chan.final_day <= final_day;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid after the last word of a burst
   task automatic park_request();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   // Wait until every expected word is back and the pipeline has emptied
   task automatic settle();
      while (ledger.pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      ledger.set_register(idx, value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Set all four registers while the block is idle
   task automatic configure(logic [CSR_DATA_W-1:0] wlen, logic [CSR_DATA_W-1:0] maxpos,
                            logic [CSR_DATA_W-1:0] low_lvl, logic [CSR_DATA_W-1:0] high_lvl);
      settle();
      write_reg(CSR_WINDOW_LENGTH, wlen);
      write_reg(CSR_MAX_POSITION, maxpos);
      write_reg(CSR_OVERSOLD_LEVEL, low_lvl);
      write_reg(CSR_OVERBOUGHT_LEVEL, high_lvl);
   endtask

   // Random walk with drifting trend, broken up by jumps to arbitrary prices
   task automatic run_days(int unsigned count);
      int unsigned roll;
      int          next;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) trend = int'($urandom_range(0, 2)) - 1;
         roll = $urandom_range(0, 99);
         if (roll < 4) next = int'($urandom_range(0, PRICE_TOP));
         else if (roll == 4) next = 0;
         else if (roll == 5) next = PRICE_TOP;
         else next = walk_price + trend * int'($urandom_range(0, 600))
                     + int'($urandom_range(0, 400)) - 200;
         if (next < 0) next = 0;
         if (next > PRICE_TOP) next = PRICE_TOP;
         walk_price = next;
         send_day(next[PRICE_W-1:0], $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 3);
      end
      park_request();
   endtask

   initial begin
      reset              = 1'b1;
      steady             = 1'b0;
      walk_price         = 500000;
      trend              = 0;
      req_chan.valid     = 1'b0;
      req_chan.price     = '0;
      req_chan.in_range  = 1'b0;
      req_chan.final_day = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_WINDOW_LENGTH;
      csr_wdata          = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Short window, tight limit: buys up to the limit, sells, flat days, extremes
      configure(2, 2, 30, 70);
      send_day(1000, 1, 0);
      send_day(1000, 1, 0);
      send_day(900, 1, 0);
      send_day(800, 1, 0);
      send_day(700, 1, 0);
      send_day(900, 1, 0);
      send_day(1100, 1, 0);
      send_day(PRICE_TOP, 1, 0);
      send_day(0, 1, 0);
      send_day(0, 0, 0);
      send_day(PRICE_TOP, 0, 0);
      send_day(5, 1, 1);
      send_day(0, 1, 1);
      park_request();

      // Longest window: closing days long before the window fills
      configure(64, 2, 30, 70);
      send_day(PRICE_TOP, 1, 1);
      send_day(0, 1, 0);
      send_day(PRICE_TOP, 1, 1);
      park_request();

      // Zero length acts as one; thresholds above full scale
      configure(0, 65535, 101, 127);
      send_day(10, 1, 0);
      send_day(20, 1, 0);
      send_day(30, 1, 0);
      send_day(25, 1, 1);
      park_request();

      // Random phases over a spread of settings
      configure(3, 4, 30, 70);
      run_days(210);
      configure(0, 1, 50, 50);
      run_days(210);
      steady = 1'b1;
      configure(127, 65535, 40, 60);
      run_days(210);
      steady = 1'b0;
      configure(8, 0, 100, 0);
      run_days(210);
      configure(16'hFFFF, 65535, 16'hFFFF, 16'hFFFF);
      run_days(210);
      configure(5, 3, 101, 101);
      run_days(210);
      configure(16'($urandom_range(0, 20)), 16'($urandom_range(0, 8)),
                16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)));
      run_days(210);
      configure(16'($urandom_range(1, 12)), 16'($urandom_range(1, 6)),
                16'($urandom_range(20, 50)), 16'($urandom_range(50, 80)));
      run_days(210);

      settle();
      if (ledger.mismatches == 0)
         $display("tb_rsi_threshold_trader_unit: done, clean");
      else
         $display("tb_rsi_threshold_trader_unit: done, errors");
      $finish;
   end

endmodule
